/* rtl/core/slcan_ascii_command_parser_assert.svh */
// ----------------------------------------------------------------------------
// slcan assertion macros
// Shared concurrent assertion forms for the SLCAN command parser RTL.
// ----------------------------------------------------------------------------
`ifndef SLCAN_ASCII_COMMAND_PARSER_ASSERT_SVH
`define SLCAN_ASCII_COMMAND_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLCAN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slcan assertion failed");

// next-cycle implication, disabled during reset
`define SLCAN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slcan assertion failed");

`endif

/* rtl/core/slcan_pkg.sv */
// ----------------------------------------------------------------------------
// slcan_pkg
// Types, codes and helpers for the SLCAN ASCII command parser.
// ----------------------------------------------------------------------------
package slcan_pkg;

    localparam int ID_W               = 29;
    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int POS_W              = 5;
    localparam int LEN_W              = 4;
    localparam int PAYLOAD_W          = 64;

    localparam logic [7:0] CHAR_OPEN  = 8'h4F; // 'O'
    localparam logic [7:0] CHAR_CLOSE = 8'h43; // 'C'
    localparam logic [7:0] CHAR_STD   = 8'h74; // 't'
    localparam logic [7:0] CHAR_EXT   = 8'h54; // 'T'
    localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'

    localparam logic [POS_W-1:0] ID_LEN_STD = 5'd3;
    localparam logic [POS_W-1:0] ID_LEN_EXT = 5'd8;
    localparam logic [POS_W-1:0] POS_MAX    = 5'd31;

    // top ID digit limits keep the identifier within 11 or 29 bits
    localparam logic [3:0] ID_TOP_STD = 4'd7;
    localparam logic [3:0] ID_TOP_EXT = 4'd1;

    typedef enum logic [2:0] {
        CMD_OTHER = 3'd0,
        CMD_OPEN  = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_STD   = 3'd3,
        CMD_EXT   = 3'd4
    } slcan_cmd_t;

    typedef enum logic [1:0] {
        EVT_OPEN      = 2'd0,
        EVT_CLOSE     = 2'd1,
        EVT_FRAME     = 2'd2,
        EVT_MALFORMED = 2'd3
    } slcan_event_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       buffer_end;
    } slcan_in_t;

    typedef struct packed {
        slcan_event_t         event_kind;
        logic [ID_W-1:0]      frame_id;
        logic                 extended_id;
        logic [LEN_W-1:0]     byte_count;
        logic [PAYLOAD_W-1:0] payload;
        logic                 channel_open;
    } slcan_out_t;

    // hex digit decode: bit 4 flags a non-hex byte, bits 3:0 the value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

/* rtl/core/slcan_ascii_command_parser.sv */
// A byte beat is held in the input register and then decoded into the result register.
// Throughput: one byte per cycle; the decode between the input register and
// the result register is a single pass, and the input stalls only while the
// result register is full and not being taken.
// Reset: clears both pipeline valids, the command position and the open flag.
// ----------------------------------------------------------------------------
// slcan_ascii_command_parser
// Serial-line CAN ASCII command parser: open, close and frame commands.
// ----------------------------------------------------------------------------
`include "slcan_ascii_command_parser_assert.svh"

module slcan_ascii_command_parser #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  slcan_pkg::slcan_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output slcan_pkg::slcan_out_t m_data
);
    import slcan_pkg::*;

    logic       hold_valid;
    slcan_in_t  hold_data;
    logic       out_free;
    logic       step;
    logic       emit;
    slcan_out_t result;

    // a held byte advances whenever the result slot can take a beat
    assign step = hold_valid && out_free;

    slcan_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    slcan_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_data (hold_data),
        .emit    (emit),
        .result  (result)
    );

    slcan_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step && emit),
        .result  (result),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `SLCAN_ASSERT_NOW(a_frame_opens, aclk, aresetn, m_valid && m_data.event_kind == EVT_FRAME, m_data.channel_open)
    `SLCAN_ASSERT_NOW(a_close_shuts, aclk, aresetn, m_valid && m_data.event_kind == EVT_CLOSE, !m_data.channel_open)
    `SLCAN_ASSERT_NOW(a_nonframe_zero, aclk, aresetn, m_valid && m_data.event_kind != EVT_FRAME, m_data.frame_id == '0 && m_data.payload == '0 && m_data.byte_count == '0 && !m_data.extended_id)

endmodule

/* rtl/core/slcan_in_stage.sv */
// ----------------------------------------------------------------------------
// slcan_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module slcan_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  slcan_pkg::slcan_in_t  s_data,
    input  logic                  take,
    output logic                  hold_valid,
    output slcan_pkg::slcan_in_t  hold_data
);
    import slcan_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    slcan_in_t data_reg;

    // free when empty or being drained this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

/* rtl/core/slcan_parser.sv */
// ----------------------------------------------------------------------------
// slcan_parser
// Command state and per-byte decode; builds the result on the last byte.
// ----------------------------------------------------------------------------
`include "slcan_ascii_command_parser_assert.svh"

module slcan_parser #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  slcan_pkg::slcan_in_t  in_data,
    output logic                  emit,
    output slcan_pkg::slcan_out_t result
);
    import slcan_pkg::*;

    localparam int NIB_N     = 2 * MAX_DATA_BYTES;
    localparam int NIB_IDX_W = (NIB_N > 1) ? $clog2(NIB_N) : 1;

    // parse state
    slcan_cmd_t                cmd_reg,  cmd_next;
    logic [POS_W-1:0]          pos_reg,  pos_next;
    logic [ID_W-1:0]           id_reg,   id_next;
    logic [LEN_W-1:0]          len_reg,  len_next;
    logic [NIB_N-1:0][3:0]     data_reg, data_next;
    logic                      err_reg,  err_next;
    logic                      open_reg, open_next;

    logic [7:0]           c;
    logic [4:0]           hex;
    logic                 is_ext;
    logic [POS_W-1:0]     id_len;
    logic [3:0]           id_top;
    logic [7:0]           dlc_digit;
    logic [POS_W:0]       data_last;
    logic [POS_W:0]       received;
    logic [POS_W:0]       needed;
    logic [POS_W-1:0]     k_full;
    logic [NIB_IDX_W-1:0] nib;
    logic                 frame_ok;

    assign c      = in_data.char_in;
    assign hex    = hex_decode(c);
    assign is_ext = (cmd_reg == CMD_EXT);
    assign id_len = is_ext ? ID_LEN_EXT : ID_LEN_STD;
    assign id_top = is_ext ? ID_TOP_EXT : ID_TOP_STD;

    assign dlc_digit = c - CHAR_ZERO;
    assign data_last = {1'b0, id_len} + (POS_W+1)'(1) + {1'b0, len_reg, 1'b0};
    assign k_full    = pos_reg - id_len - POS_W'(2);
    // high nibble of each byte arrives first
    assign nib       = NIB_IDX_W'(k_full) ^ NIB_IDX_W'(1);

    // byte decode and state update
    always_comb begin
        cmd_next  = cmd_reg;
        pos_next  = pos_reg;
        id_next   = id_reg;
        len_next  = len_reg;
        data_next = data_reg;
        err_next  = err_reg;
        open_next = open_reg;
        emit      = 1'b0;
        result    = '0;
        received  = {1'b0, pos_reg} + (POS_W+1)'(1);
        needed    = '0;
        frame_ok  = 1'b0;

        if (pos_reg == '0) begin
            id_next   = '0;
            len_next  = '0;
            data_next = '0;
            err_next  = 1'b0;
            priority if (c == CHAR_OPEN) begin
                cmd_next = CMD_OPEN;
            end else if (c == CHAR_CLOSE) begin
                cmd_next = CMD_CLOSE;
            end else if (c == CHAR_STD) begin
                cmd_next = CMD_STD;
            end else if (c == CHAR_EXT) begin
                cmd_next = CMD_EXT;
            end else begin
                cmd_next = CMD_OTHER;
            end
        end else if (cmd_reg == CMD_STD || cmd_reg == CMD_EXT) begin
            priority if (pos_reg <= id_len) begin
                // identifier digit
                if (hex[4]) begin
                    err_next = 1'b1;
                end else begin
                    if (pos_reg == POS_W'(1) && hex[3:0] > id_top) begin
                        err_next = 1'b1;
                    end
                    id_next = {id_reg[ID_W-5:0], hex[3:0]};
                end
            end else if (pos_reg == id_len + POS_W'(1)) begin
                // length digit
                if (c < CHAR_ZERO || c > CHAR_NINE || dlc_digit > 8'(MAX_DATA_BYTES)) begin
                    err_next = 1'b1;
                    len_next = '0;
                end else begin
                    len_next = dlc_digit[LEN_W-1:0];
                end
            end else if ({1'b0, pos_reg} <= data_last) begin
                // data digit
                if (hex[4]) begin
                    err_next = 1'b1;
                end else begin
                    data_next[nib] = data_reg[nib] | hex[3:0];
                end
            end else begin
                // trailing bytes are ignored
                err_next = err_reg;
            end
        end

        if (in_data.buffer_end) begin
            pos_next = '0;
            needed   = {1'b0, (cmd_next == CMD_EXT) ? ID_LEN_EXT : ID_LEN_STD}
                       + (POS_W+1)'(2) + {1'b0, len_next, 1'b0};
            frame_ok = !err_next && (received >= needed);
            unique case (cmd_next)
                CMD_OPEN: begin
                    emit              = 1'b1;
                    open_next         = 1'b1;
                    result.event_kind = EVT_OPEN;
                end
                CMD_CLOSE: begin
                    emit              = 1'b1;
                    open_next         = 1'b0;
                    result.event_kind = EVT_CLOSE;
                end
                CMD_STD, CMD_EXT: begin
                    emit = 1'b1;
                    if (frame_ok) begin
                        open_next          = 1'b1;
                        result.event_kind  = EVT_FRAME;
                        result.frame_id    = id_next;
                        result.extended_id = (cmd_next == CMD_EXT);
                        result.byte_count  = len_next;
                        result.payload     = PAYLOAD_W'(data_next);
                    end else begin
                        result.event_kind  = EVT_MALFORMED;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
            result.channel_open = open_next;
        end else if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg  <= CMD_OTHER;
            pos_reg  <= '0;
            open_reg <= 1'b0;
        end else if (step) begin
            cmd_reg  <= cmd_next;
            pos_reg  <= pos_next;
            open_reg <= open_next;
        end
    end

    // accumulators, cleared by the first byte of every command
    always_ff @(posedge aclk) begin
        if (step) begin
            id_reg   <= id_next;
            len_reg  <= len_next;
            data_reg <= data_next;
            err_reg  <= err_next;
        end
    end

    `SLCAN_ASSERT_NEXT(a_pos_rewind, aclk, aresetn, step && in_data.buffer_end, pos_reg == '0)
    `SLCAN_ASSERT_NOW(a_emit_on_end, aclk, aresetn, emit, in_data.buffer_end)
    `SLCAN_ASSERT_NOW(a_len_bound, aclk, aresetn, pos_reg != '0, len_reg <= LEN_W'(MAX_DATA_BYTES))

endmodule

/* rtl/core/slcan_out_stage.sv */
// ----------------------------------------------------------------------------
// slcan_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module slcan_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  slcan_pkg::slcan_out_t  result,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slcan_pkg::slcan_out_t  m_data
);
    import slcan_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    slcan_out_t data_reg;

    // slot is free when empty or draining this cycle
    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
